### design/encfv_pkg.sv
// ----------------------------------------------------------------------------
// encfv_pkg
// Shared types and constants for the encoder filter and window velocity block.
// ----------------------------------------------------------------------------
package encfv_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOCKOUT = 3'd0,
      CSR_CONFIRM = 3'd1,
      CSR_B_GAP   = 3'd2,
      CSR_PERIOD  = 3'd3,
      CSR_SCALE   = 3'd4
   } csr_index_type;

   localparam logic [15:0] LOCKOUT_RST = 16'd400;
   localparam logic [7:0]  CONFIRM_RST = 8'd10;
   localparam logic [7:0]  B_GAP_RST   = 8'd5;
   localparam logic [23:0] PERIOD_RST  = 24'd1000000;
   localparam logic [15:0] SCALE_RST   = 16'd5662;

   localparam int QUEUE_DEPTH = 4;

   // velocity datapath
   localparam int MAG_W   = 41;
   localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
   localparam int SPLIT_W = 24;
   localparam int PROD_W  = MAG_W + 17;
   localparam int DIVD_W  = PROD_W - 16;
   localparam int DCNT_W  = $clog2(DIVD_W);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_CONFIRM = 3'b010,
      PH_GAP     = 3'b100
   } phase_type;

   typedef enum logic [4:0] {
      BK_IDLE   = 5'b00001,
      BK_MUL_LO = 5'b00010,
      BK_MUL_HI = 5'b00100,
      BK_DIV    = 5'b01000,
      BK_DONE   = 5'b10000
   } back_state_type;

   typedef struct packed {
      logic taken;
      logic updated;
      logic do_speed;
   } tick_ctrl_type;

endpackage

### design/encfv_queue.sv
// ----------------------------------------------------------------------------
// encfv_queue
// Small register FIFO between the tick front end and the velocity back end.
// ----------------------------------------------------------------------------
module encfv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/encfv_front.sv
// ----------------------------------------------------------------------------
// encfv_front
// Per-tick pulse qualifier, position counter and snapshot ring.
// ----------------------------------------------------------------------------
module encfv_front
   import encfv_pkg::*;
#(
   parameter int WINDOW    = 10,
   parameter int POS_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            tick_valid,
   output logic                            tick_ready,
   input  logic                            line_a,
   input  logic                            line_b,
   input  logic [15:0]                     lockout_ticks,
   input  logic [7:0]                      confirm_samples,
   input  logic [7:0]                      b_gap_ticks,
   input  logic [23:0]                     update_period_ticks,
   output logic                            push_valid,
   input  logic                            push_ready,
   output tick_ctrl_type                   push_ctrl,
   output logic [31:0]                     push_pos,
   output logic [POS_WIDTH-1:0]            push_delta,
   output logic [$clog2(WINDOW+1)-1:0]     push_n
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int N_W    = $clog2(WINDOW + 1);
   localparam int OUT_W  = (POS_WIDTH > 32) ? POS_WIDTH : 32;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [15:0]          since_ff, since_in;
   phase_type            phase_ff, phase_in;
   logic [7:0]           pcnt_ff, pcnt_in;
   logic                 first_b_ff, first_b_in;
   logic                 prev_a_ff, prev_a_in;
   logic [23:0]          period_ff, period_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 full_ff, full_in;
   logic [POS_WIDTH-1:0] ring_ff [WINDOW];

   logic                 accept;
   logic                 take;
   logic                 snap;
   logic [7:0]           pcnt_inc;
   logic [8:0]           lock_sum;
   logic [23:0]          period_inc;
   logic [SLOT_W-1:0]    rd_idx;
   logic [POS_WIDTH-1:0] oldest;
   logic [OUT_W-1:0]     pos_ext;

   assign tick_ready = push_ready;
   assign push_valid = tick_valid;
   assign accept     = tick_valid && push_ready;
   assign pcnt_inc   = pcnt_ff + 8'd1;
   assign lock_sum   = {1'b0, confirm_samples} + {1'b0, b_gap_ticks};
   assign period_inc = period_ff + 24'd1;
   assign snap       = (period_inc >= update_period_ticks);
   assign rd_idx     = full_ff ? slot_ff : '0;
   assign oldest     = ring_ff[rd_idx];

   always_comb begin
      pos_in     = pos_ff;
      since_in   = since_ff;
      phase_in   = phase_ff;
      pcnt_in    = pcnt_ff;
      first_b_in = first_b_ff;
      prev_a_in  = prev_a_ff;
      period_in  = period_ff;
      slot_in    = slot_ff;
      full_in    = full_ff;
      take       = 1'b0;
      if (accept) begin
         if (since_ff != 16'hFFFF) begin
            since_in = since_ff + 16'd1;
         end
         unique case (phase_ff)
            PH_CONFIRM: begin
               if (!line_a) begin
                  phase_in = PH_IDLE;
               end else begin
                  pcnt_in = pcnt_inc;
                  if (pcnt_inc >= confirm_samples) begin
                     first_b_in = line_b;
                     pcnt_in    = '0;
                     if (b_gap_ticks == '0) begin
                        phase_in = PH_IDLE;
                        take     = 1'b1;
                     end else begin
                        phase_in = PH_GAP;
                     end
                  end
               end
            end
            PH_GAP: begin
               pcnt_in = pcnt_inc;
               if (pcnt_inc >= b_gap_ticks) begin
                  phase_in = PH_IDLE;
                  pcnt_in  = '0;
                  take     = (line_b == first_b_ff);
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (line_a && !prev_a_ff && since_in >= lockout_ticks) begin
                  phase_in = PH_CONFIRM;
                  pcnt_in  = '0;
               end
            end
         endcase
         if (take) begin
            pos_in   = line_b ? pos_ff - 1'b1 : pos_ff + 1'b1;
            since_in = 16'(lock_sum);
         end
         prev_a_in = line_a;
         period_in = period_inc;
         if (snap) begin
            period_in = '0;
            slot_in   = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               full_in = 1'b1;
            end
         end
      end
   end

   assign pos_ext             = OUT_W'(pos_in);
   assign push_pos            = pos_ext[31:0];
   assign push_delta          = pos_in - oldest;
   assign push_n              = full_ff ? N_W'(WINDOW) : N_W'(slot_ff);
   assign push_ctrl.taken     = take;
   assign push_ctrl.updated   = snap;
   assign push_ctrl.do_speed  = snap && (full_ff || slot_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         since_ff   <= '0;
         phase_ff   <= PH_IDLE;
         pcnt_ff    <= '0;
         first_b_ff <= 1'b0;
         prev_a_ff  <= 1'b1;
         period_ff  <= '0;
         slot_ff    <= '0;
         full_ff    <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         since_ff   <= since_in;
         phase_ff   <= phase_in;
         pcnt_ff    <= pcnt_in;
         first_b_ff <= first_b_in;
         prev_a_ff  <= prev_a_in;
         period_ff  <= period_in;
         slot_ff    <= slot_in;
         full_ff    <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && snap) begin
         ring_ff[slot_ff] <= pos_in;
      end
   end

endmodule

### design/encfv_back.sv
// ----------------------------------------------------------------------------
// encfv_back
// Velocity sequencer: split multiply, bit-serial divide, saturate, result register.
// ----------------------------------------------------------------------------
module encfv_back
   import encfv_pkg::*;
#(
   parameter int WINDOW    = 10,
   parameter int POS_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  tick_ctrl_type               pop_ctrl,
   input  logic [31:0]                 pop_pos,
   input  logic [POS_WIDTH-1:0]        pop_delta,
   input  logic [$clog2(WINDOW+1)-1:0] pop_n,
   input  logic [15:0]                 velocity_scale,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [31:0]                 rsp_pos,
   output logic [15:0]                 rsp_speed,
   output logic                        rsp_seen,
   output tick_ctrl_type               rsp_ctrl
);

   localparam int N_W   = $clog2(WINDOW + 1);
   localparam int EXT_W = (POS_WIDTH > MAG_W) ? POS_WIDTH : MAG_W;

   back_state_type       st_ff, st_in;
   logic [31:0]          ent_pos_ff;
   tick_ctrl_type        ent_ctrl_ff;
   logic                 neg_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [N_W-1:0]       n_ff;
   logic [PROD_W-1:0]    acc_ff;
   logic [DIVD_W-1:0]    quo_ff;
   logic [N_W-1:0]       rem_ff;
   logic [DCNT_W-1:0]    dcnt_ff;
   logic [15:0]          speed_ff;
   logic                 seen_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_pos_ff;
   logic [15:0]          rsp_speed_ff;
   logic                 rsp_seen_ff;
   tick_ctrl_type        rsp_ctrl_ff;

   logic                 out_free;
   logic                 load_plain;
   logic                 load_speed;
   logic [POS_WIDTH-1:0] abs_delta;
   logic [EXT_W-1:0]     abs_ext;
   logic [MAG_W-1:0]     mag_clamped;
   logic [PROD_W-1:0]    prod_lo;
   logic [PROD_W-1:0]    prod_hi;
   logic [PROD_W-1:0]    acc_sum;
   logic [N_W:0]         trial;
   logic                 trial_ge;
   logic [15:0]          speed_res;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_plain = (st_ff == BK_IDLE) && pop_valid && !pop_ctrl.do_speed && out_free;
   assign load_speed = (st_ff == BK_DONE) && out_free;
   assign pop_ready  = (st_ff == BK_IDLE) && (pop_ctrl.do_speed || out_free);

   assign abs_delta   = pop_delta[POS_WIDTH-1] ? (~pop_delta + 1'b1) : pop_delta;
   assign abs_ext     = EXT_W'(abs_delta);
   assign mag_clamped = (abs_ext > EXT_W'(MAG_LIMIT)) ? MAG_LIMIT : abs_ext[MAG_W-1:0];

   assign prod_lo = PROD_W'({16'd0, mag_ff[SPLIT_W-1:0]}
                            * {{SPLIT_W{1'b0}}, velocity_scale})
                  + (PROD_W'(n_ff) << 15);
   assign prod_hi = PROD_W'({16'd0, mag_ff[MAG_W-1:SPLIT_W]}
                            * {{(MAG_W-SPLIT_W){1'b0}}, velocity_scale}) << SPLIT_W;
   assign acc_sum = acc_ff + prod_hi;

   assign trial    = {rem_ff, quo_ff[DIVD_W-1]};
   assign trial_ge = (trial >= {1'b0, n_ff});

   always_comb begin
      if (!neg_ff) begin
         speed_res = (quo_ff > DIVD_W'(32768)) ? 16'h8000 : (16'd0 - quo_ff[15:0]);
      end else begin
         speed_res = (quo_ff > DIVD_W'(32767)) ? 16'h7FFF : quo_ff[15:0];
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE:   if (pop_valid && pop_ctrl.do_speed) begin
            st_in = BK_MUL_LO;
         end
         BK_MUL_LO: st_in = BK_MUL_HI;
         BK_MUL_HI: st_in = BK_DIV;
         BK_DIV:    if (dcnt_ff == DCNT_W'(DIVD_W - 1)) begin
            st_in = BK_DONE;
         end
         BK_DONE:   if (out_free) begin
            st_in = BK_IDLE;
         end
         default:   st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         speed_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (load_speed) begin
            speed_ff <= speed_res;
            seen_ff  <= 1'b1;
         end
         if (load_plain || load_speed) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         BK_IDLE: begin
            ent_pos_ff  <= pop_pos;
            ent_ctrl_ff <= pop_ctrl;
            neg_ff      <= pop_delta[POS_WIDTH-1];
            mag_ff      <= mag_clamped;
            n_ff        <= pop_n;
         end
         BK_MUL_LO: acc_ff <= prod_lo;
         BK_MUL_HI: begin
            quo_ff  <= acc_sum[PROD_W-1:16];
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         BK_DIV: begin
            rem_ff  <= trial_ge ? N_W'(trial - {1'b0, n_ff}) : N_W'(trial);
            quo_ff  <= {quo_ff[DIVD_W-2:0], trial_ge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (load_plain) begin
         rsp_pos_ff   <= pop_pos;
         rsp_speed_ff <= speed_ff;
         rsp_seen_ff  <= seen_ff;
         rsp_ctrl_ff  <= pop_ctrl;
      end else if (load_speed) begin
         rsp_pos_ff   <= ent_pos_ff;
         rsp_speed_ff <= speed_res;
         rsp_seen_ff  <= 1'b1;
         rsp_ctrl_ff  <= ent_ctrl_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos   = rsp_pos_ff;
   assign rsp_speed = rsp_speed_ff;
   assign rsp_seen  = rsp_seen_ff;
   assign rsp_ctrl  = rsp_ctrl_ff;

endmodule

### design/encoder_filter_window_velocity.sv
// ----------------------------------------------------------------------------
// encoder_filter_window_velocity
// Filtered quadrature pulse counter with a moving-window velocity estimate.
//
// Each request on req_ is one sample tick of encoder lines A and B. Every
// request gives exactly one response on rsp_ with the position, the latest
// velocity and the pulse and snapshot flags of that tick. Registers are
// written on csr_ (index, data); write them only while no request is in
// flight, which the block itself does not enforce. csr_ready stays high.
// A tick without a velocity refresh passes the queue into the response
// register, one tick per cycle while the back end is idle and rsp_tready
// is high. A tick that refreshes the velocity holds the back end for two
// split-multiply steps and 42 steps of the one-bit-per-cycle divider,
// plus entry and output. The front end keeps taking requests into a
// 4-entry queue meanwhile; req_tready drops when the queue is full.
// When rsp_tready is low the response register holds and the queue fills.
// Reset (synchronous) clears position, timers, ring pointer and velocity and
// loads the register defaults; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module encoder_filter_window_velocity
   import encfv_pkg::*;
#(
   parameter int WINDOW    = 10,
   parameter int POS_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // line_a, line_b
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [55:0]            rsp_tdata,   // count_position, speed_mm_s,
                                               // speed_valid, pulse_taken,
                                               // window_updated
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int N_W = $clog2(WINDOW + 1);
   localparam int Q_W = $bits(tick_ctrl_type) + 32 + POS_WIDTH + N_W;

   logic [15:0]          lockout_ff;
   logic [7:0]           confirm_ff;
   logic [7:0]           gap_ff;
   logic [23:0]          period_ff;
   logic [15:0]          scale_ff;

   logic                 f_valid, f_ready;
   tick_ctrl_type        f_ctrl;
   logic [31:0]          f_pos;
   logic [POS_WIDTH-1:0] f_delta;
   logic [N_W-1:0]       f_n;
   logic [Q_W-1:0]       q_in_data, q_out_data;
   logic                 b_valid, b_ready;
   tick_ctrl_type        b_ctrl;
   logic [31:0]          b_pos;
   logic [POS_WIDTH-1:0] b_delta;
   logic [N_W-1:0]       b_n;

   logic [31:0]          r_pos;
   logic [15:0]          r_speed;
   logic                 r_seen;
   tick_ctrl_type        r_ctrl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RST;
         confirm_ff <= CONFIRM_RST;
         gap_ff     <= B_GAP_RST;
         period_ff  <= PERIOD_RST;
         scale_ff   <= SCALE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOCKOUT: lockout_ff <= csr_data[15:0];
            CSR_CONFIRM: confirm_ff <= csr_data[7:0];
            CSR_B_GAP:   gap_ff     <= csr_data[7:0];
            CSR_PERIOD:  period_ff  <= csr_data[23:0];
            CSR_SCALE:   scale_ff   <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   encfv_front #(
      .WINDOW    (WINDOW),
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .tick_valid          (req_tvalid),
      .tick_ready          (req_tready),
      .line_a              (req_tdata[0]),
      .line_b              (req_tdata[1]),
      .lockout_ticks       (lockout_ff),
      .confirm_samples     (confirm_ff),
      .b_gap_ticks         (gap_ff),
      .update_period_ticks (period_ff),
      .push_valid          (f_valid),
      .push_ready          (f_ready),
      .push_ctrl           (f_ctrl),
      .push_pos            (f_pos),
      .push_delta          (f_delta),
      .push_n              (f_n)
   );

   assign q_in_data = {f_ctrl, f_pos, f_delta, f_n};

   encfv_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (q_out_data)
   );

   assign {b_ctrl, b_pos, b_delta, b_n} = q_out_data;

   encfv_back #(
      .WINDOW    (WINDOW),
      .POS_WIDTH (POS_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (b_valid),
      .pop_ready      (b_ready),
      .pop_ctrl       (b_ctrl),
      .pop_pos        (b_pos),
      .pop_delta      (b_delta),
      .pop_n          (b_n),
      .velocity_scale (scale_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_pos        (r_pos),
      .rsp_speed      (r_speed),
      .rsp_seen       (r_seen),
      .rsp_ctrl       (r_ctrl)
   );

   assign rsp_tdata = {5'd0, r_ctrl.updated, r_ctrl.taken, r_seen, r_speed, r_pos};

endmodule
